/* src/tst_pkg.sv */
// Shared widths, codes and types for the touch swipe tracker.
`default_nettype none

package tst_pkg;

	localparam int TS_W       = 32;
	localparam int CNT_W      = 4;
	localparam int RAW_W      = 12;
	localparam int POS_W      = 9;
	localparam int GEST_W     = 2;
	localparam int THR_W      = 12;
	localparam int TMO_W      = 16;
	localparam int MAG_W      = RAW_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int PANEL_WIDTH_DEF  = 280;
	localparam int PANEL_HEIGHT_DEF = 456;

	localparam logic [THR_W-1:0] THRESH_RST  = THR_W'(45);
	localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(80);

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ONLINE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SWIPE_THRESH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TMO   = CFG_IDX_W'(2);

	localparam logic [GEST_W-1:0] GEST_NONE  = GEST_W'(0);
	localparam logic [GEST_W-1:0] GEST_LEFT  = GEST_W'(1);
	localparam logic [GEST_W-1:0] GEST_RIGHT = GEST_W'(2);

	typedef struct packed {
		logic             device_online;
		logic [THR_W-1:0] swipe_threshold;
		logic [TMO_W-1:0] release_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [TS_W-1:0]  now_ms;
		logic             count_read_ok;
		logic [CNT_W-1:0] point_count;
		logic             coord_read_ok;
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
	} poll_t;

endpackage

`default_nettype wire

/* src/tst_if.sv */
// Channel interfaces: poll input, result output and register write.
`default_nettype none

interface tst_poll_if
	import tst_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [TS_W-1:0]  now_ms;
	logic             count_read_ok;
	logic [CNT_W-1:0] point_count;
	logic             coord_read_ok;
	logic [RAW_W-1:0] raw_x;
	logic [RAW_W-1:0] raw_y;

	modport source (output valid, now_ms, count_read_ok, point_count, coord_read_ok,
		raw_x, raw_y, input ready);
	modport sink (input valid, now_ms, count_read_ok, point_count, coord_read_ok,
		raw_x, raw_y, output ready);
endinterface

interface tst_res_if
	import tst_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              pressed;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [GEST_W-1:0] gesture;

	modport source (output valid, pressed, pos_x, pos_y, gesture, input ready);
	modport sink (input valid, pressed, pos_x, pos_y, gesture, output ready);
endinterface

interface tst_cfg_if
	import tst_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/touch_swipe_tracker_core.sv */
// Top level: poll register, single-pass tracking logic and result register.
// A transferred poll passes through the poll register and then the result register.
// Throughput: one poll per cycle while the result register is not stalled; the
// state update for a poll is computed combinationally between the two registers.
// A stalled result register holds the poll register, which then holds input.
// Reset (arst_n low, asynchronous) empties both registers and clears all
// tracking state; registers return to online 0, threshold 45, timeout 80 ms.
`default_nettype none

module touch_swipe_tracker_core
	import tst_pkg::*;
#(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tst_poll_if.sink   poll,
	tst_res_if.source  res,
	tst_cfg_if.sink    cfg
);

	localparam int XW = $clog2(PANEL_HEIGHT);
	localparam int YW = $clog2(PANEL_WIDTH);
	localparam logic [RAW_W-1:0] X_TOP = RAW_W'(PANEL_WIDTH - 1);
	localparam logic [RAW_W-1:0] Y_TOP = RAW_W'(PANEL_HEIGHT - 1);

	cfg_t cfg_q;

	tst_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	poll_t poll_s1;
	logic  poll_valid_s1;
	logic  advance;

	logic              out_valid_q;
	logic              out_pressed_q;
	logic [POS_W-1:0]  out_pos_x_q;
	logic [POS_W-1:0]  out_pos_y_q;
	logic [GEST_W-1:0] out_gesture_q;

	logic          tracking_q;
	logic          gesture_done_q;
	logic [XW-1:0] start_x_q;
	logic [YW-1:0] start_y_q;
	logic [TS_W-1:0] last_event_q;
	logic          pressed_q;
	logic [XW-1:0] cur_x_q;
	logic [YW-1:0] cur_y_q;

	logic          tracking_d;
	logic          gesture_done_d;
	logic [XW-1:0] start_x_d;
	logic [YW-1:0] start_y_d;
	logic [TS_W-1:0] last_event_d;
	logic          pressed_d;
	logic [XW-1:0] cur_x_d;
	logic [YW-1:0] cur_y_d;
	logic [GEST_W-1:0] gesture_d;

	logic [TS_W-1:0]  elapsed;
	logic             timed_out;
	logic [RAW_W-1:0] cx;
	logic [RAW_W-1:0] cy;
	logic [XW-1:0]    new_x;
	logic [YW-1:0]    new_y;
	logic signed [MAG_W-1:0] dx;
	logic signed [MAG_W-1:0] dy;
	logic [MAG_W-1:0] adx;
	logic [MAG_W-1:0] ady;
	logic             swipe;

	assign advance    = poll_valid_s1 && (!out_valid_q || res.ready);
	assign poll.ready = !poll_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			poll_valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			poll_s1.now_ms        <= poll.now_ms;
			poll_s1.count_read_ok <= poll.count_read_ok;
			poll_s1.point_count   <= poll.point_count;
			poll_s1.coord_read_ok <= poll.coord_read_ok;
			poll_s1.raw_x         <= poll.raw_x;
			poll_s1.raw_y         <= poll.raw_y;
		end
	end

	assign elapsed   = poll_s1.now_ms - last_event_q;
	assign timed_out = elapsed > TS_W'(cfg_q.release_timeout_ms);

	assign cx    = (poll_s1.raw_x > X_TOP) ? X_TOP : poll_s1.raw_x;
	assign cy    = (poll_s1.raw_y > Y_TOP) ? Y_TOP : poll_s1.raw_y;
	assign new_x = XW'(Y_TOP - cy);
	assign new_y = YW'(cx);

	assign dx  = $signed(MAG_W'(new_x)) - $signed(MAG_W'(start_x_q));
	assign dy  = $signed(MAG_W'(new_y)) - $signed(MAG_W'(start_y_q));
	assign adx = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
	assign ady = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
	assign swipe = (adx > MAG_W'(cfg_q.swipe_threshold)) && (adx > ady);

	always_comb begin
		tracking_d     = tracking_q;
		gesture_done_d = gesture_done_q;
		start_x_d      = start_x_q;
		start_y_d      = start_y_q;
		last_event_d   = last_event_q;
		pressed_d      = pressed_q;
		cur_x_d        = cur_x_q;
		cur_y_d        = cur_y_q;
		gesture_d      = GEST_NONE;
		priority if (!cfg_q.device_online) begin
			pressed_d = 1'b0;
		end else if (!poll_s1.count_read_ok) begin
			if (timed_out) begin
				pressed_d  = 1'b0;
				tracking_d = 1'b0;
			end
		end else if (poll_s1.point_count == '0) begin
			if (timed_out) begin
				pressed_d      = 1'b0;
				tracking_d     = 1'b0;
				gesture_done_d = 1'b0;
			end
		end else if (poll_s1.coord_read_ok) begin
			cur_x_d = new_x;
			cur_y_d = new_y;
			if (!tracking_q) begin
				start_x_d      = new_x;
				start_y_d      = new_y;
				tracking_d     = 1'b1;
				gesture_done_d = 1'b0;
			end else if (!gesture_done_q && swipe) begin
				gesture_d      = dx[MAG_W-1] ? GEST_LEFT : GEST_RIGHT;
				gesture_done_d = 1'b1;
			end
			pressed_d    = 1'b1;
			last_event_d = poll_s1.now_ms;
		end else begin
			// hold all state on a failed coordinate read
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q     <= 1'b0;
			gesture_done_q <= 1'b0;
			start_x_q      <= '0;
			start_y_q      <= '0;
			last_event_q   <= '0;
			pressed_q      <= 1'b0;
			cur_x_q        <= '0;
			cur_y_q        <= '0;
		end else if (advance) begin
			tracking_q     <= tracking_d;
			gesture_done_q <= gesture_done_d;
			start_x_q      <= start_x_d;
			start_y_q      <= start_y_d;
			last_event_q   <= last_event_d;
			pressed_q      <= pressed_d;
			cur_x_q        <= cur_x_d;
			cur_y_q        <= cur_y_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pressed_q <= pressed_d;
			out_pos_x_q   <= POS_W'(cur_x_d);
			out_pos_y_q   <= POS_W'(cur_y_d);
			out_gesture_q <= gesture_d;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.pressed = out_pressed_q;
	assign res.pos_x   = out_pos_x_q;
	assign res.pos_y   = out_pos_y_q;
	assign res.gesture = out_gesture_q;

`ifndef SYNTH
	a_gesture_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.gesture != GEST_NONE |-> res.pressed)
		else $error("gesture reported without pressed");

	a_offline_released: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !cfg_q.device_online |=> !pressed_q && !out_pressed_q)
		else $error("pressed set while device offline");

	a_gesture_once: assert property (@(posedge clk) disable iff (!arst_n)
		advance && gesture_d != GEST_NONE |=> gesture_done_q && tracking_q)
		else $error("swipe did not latch gesture_done");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> poll.ready)
		else $error("poll stalled with result register empty");
`endif

endmodule

`default_nettype wire

/* src/tst_cfg_regs.sv */
// Configuration register file for the touch swipe tracker.
`default_nettype none

module tst_cfg_regs
	import tst_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	tst_cfg_if.sink   cfg,
	output cfg_t      cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_online      <= 1'b0;
			cfg_q.swipe_threshold    <= THRESH_RST;
			cfg_q.release_timeout_ms <= TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEVICE_ONLINE: cfg_q.device_online      <= cfg.data[0];
				REG_SWIPE_THRESH:  cfg_q.swipe_threshold    <= cfg.data[THR_W-1:0];
				REG_RELEASE_TMO:   cfg_q.release_timeout_ms <= cfg.data[TMO_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* dv/tst_tracker_checker.sv */
// Checker for the touch swipe tracker: tracks every poll transfer and checks each result.
`default_nettype none

module tst_tracker_checker
	import tst_pkg::*;
#(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tst_poll_if  poll,
	tst_res_if   res,
	tst_cfg_if   cfg,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic              pressed;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [GEST_W-1:0] gesture;
	} reading_t;

	reading_t readings_due[$];

	logic             online;
	logic [THR_W-1:0] thr;
	logic [TMO_W-1:0] tmo;

	logic             tracking;
	logic             swipe_done;
	logic             is_pressed;
	logic [POS_W-1:0] start_x;
	logic [POS_W-1:0] start_y;
	logic [POS_W-1:0] cur_x;
	logic [POS_W-1:0] cur_y;
	logic [TS_W-1:0]  last_touch_ms;

	function automatic reading_t track_poll(input poll_t p);
		reading_t        r;
		logic [TS_W-1:0] since;
		logic            idle;
		int              cx, cy, dx, dy, adx, ady;
		since = p.now_ms - last_touch_ms;
		idle = since > TS_W'(tmo);
		r.gesture = GEST_NONE;
		if (!online) begin
			is_pressed = 1'b0;
		end else if (!p.count_read_ok) begin
			if (idle) begin
				is_pressed = 1'b0;
				tracking = 1'b0;
			end
		end else if (p.point_count == '0) begin
			if (idle) begin
				is_pressed = 1'b0;
				tracking = 1'b0;
				swipe_done = 1'b0;
			end
		end else if (p.coord_read_ok) begin
			cx = (int'(p.raw_x) > PANEL_WIDTH - 1) ? PANEL_WIDTH - 1 : int'(p.raw_x);
			cy = (int'(p.raw_y) > PANEL_HEIGHT - 1) ? PANEL_HEIGHT - 1 : int'(p.raw_y);
			cur_x = POS_W'(PANEL_HEIGHT - 1 - cy);
			cur_y = POS_W'(cx);
			if (!tracking) begin
				start_x = cur_x;
				start_y = cur_y;
				tracking = 1'b1;
				swipe_done = 1'b0;
			end else if (!swipe_done) begin
				dx = int'(cur_x) - int'(start_x);
				dy = int'(cur_y) - int'(start_y);
				adx = dx < 0 ? -dx : dx;
				ady = dy < 0 ? -dy : dy;
				if (adx > int'(thr) && adx > ady) begin
					r.gesture = dx < 0 ? GEST_LEFT : GEST_RIGHT;
					swipe_done = 1'b1;
				end
			end
			is_pressed = 1'b1;
			last_touch_ms = p.now_ms;
		end
		r.pressed = is_pressed;
		r.pos_x = cur_x;
		r.pos_y = cur_y;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		poll_t    p;
		if (!arst_n) begin
			readings_due.delete();
			online = 1'b0;
			thr = THRESH_RST;
			tmo = TIMEOUT_RST;
			tracking = 1'b0;
			swipe_done = 1'b0;
			is_pressed = 1'b0;
			start_x = '0;
			start_y = '0;
			cur_x = '0;
			cur_y = '0;
			last_touch_ms = '0;
			errors = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DEVICE_ONLINE: online = cfg.data[0];
					REG_SWIPE_THRESH:  thr = cfg.data[THR_W-1:0];
					REG_RELEASE_TMO:   tmo = cfg.data[TMO_W-1:0];
					default: ;
				endcase
			end
			if (poll.valid && poll.ready) begin
				p.now_ms = poll.now_ms;
				p.count_read_ok = poll.count_read_ok;
				p.point_count = poll.point_count;
				p.coord_read_ok = poll.coord_read_ok;
				p.raw_x = poll.raw_x;
				p.raw_y = poll.raw_y;
				readings_due.push_back(track_poll(p));
			end
			if (res.valid && res.ready) begin
				if (readings_due.size() == 0) begin
					report_mismatch("unexpected result, pos_x", int'(res.pos_x), 0);
				end else begin
					want = readings_due.pop_front();
					if (res.pressed !== want.pressed)
						report_mismatch("pressed", int'(res.pressed), int'(want.pressed));
					if (res.pos_x !== want.pos_x)
						report_mismatch("pos_x", int'(res.pos_x), int'(want.pos_x));
					if (res.pos_y !== want.pos_y)
						report_mismatch("pos_y", int'(res.pos_y), int'(want.pos_y));
					if (res.gesture !== want.gesture)
						report_mismatch("gesture", int'(res.gesture), int'(want.gesture));
				end
			end
			pending = readings_due.size();
		end
	end

endmodule

`default_nettype wire

/* dv/tb_touch_swipe_tracker_core.sv */
// Testbench top for the touch swipe tracker: directed and random polls, register phases, verdict.
`default_nettype none

module tb_touch_swipe_tracker_core;
	import tst_pkg::*;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            idle_on;
	int              failures;
	int              due;
	int              polls_sent;
	int              tmo_cur;
	logic [TS_W-1:0] ms_now;

	tst_poll_if poll_ch ();
	tst_res_if  res_ch ();
	tst_cfg_if  cfg_ch ();

	touch_swipe_tracker_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	tst_tracker_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.poll    (poll_ch),
		.res     (res_ch),
		.cfg     (cfg_ch),
		.errors  (failures),
		.pending (due)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("[touch_swipe_tracker_core] ERROR");
		$finish;
	end

	initial begin
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && stall == 0 && $urandom_range(0, 4) == 0)
				stall = $urandom_range(1, 4);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic int clip_raw(input int v);
		return v < 0 ? 0 : (v > 4095 ? 4095 : v);
	endfunction

	task automatic send_poll(input logic [TS_W-1:0] ts, input logic cok,
			input logic [CNT_W-1:0] pts, input logic xok,
			input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			poll_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.now_ms <= ts;
		poll_ch.count_read_ok <= cok;
		poll_ch.point_count <= pts;
		poll_ch.coord_read_ok <= xok;
		poll_ch.raw_x <= rx;
		poll_ch.raw_y <= ry;
		do @(posedge clk); while (!poll_ch.ready);
		polls_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(input int thr, input int tmo);
		write_reg(REG_SWIPE_THRESH, {4'($urandom), RAW_W'(thr)});
		write_reg(REG_RELEASE_TMO, CFG_DATA_W'(tmo));
		tmo_cur = tmo;
	endtask

	task automatic set_online(input logic on);
		write_reg(REG_DEVICE_ONLINE, {15'($urandom), on});
	endtask

	// hold valid low and drain every outstanding result
	task automatic settle();
		poll_ch.valid <= 1'b0;
		do @(negedge clk); while (due != 0);
		@(posedge clk);
	endtask

	task automatic run_touch();
		int rx, ry, kind;
		rx = $urandom_range(0, 330);
		ry = $urandom_range(0, 520);
		if ($urandom_range(0, 7) == 0)
			ms_now = $urandom;
		else
			ms_now += $urandom_range(0, 40);
		send_poll(ms_now, 1'b1, CNT_W'($urandom_range(1, 15)), 1'b1, RAW_W'(rx), RAW_W'(ry));
		repeat ($urandom_range(1, 8)) begin
			kind = $urandom_range(0, 9);
			ms_now += $urandom_range(0, 30);
			if (kind == 0) begin
				send_poll(ms_now, 1'b1, CNT_W'($urandom_range(1, 15)), 1'b0,
					RAW_W'($urandom), RAW_W'($urandom));
			end else if (kind == 1) begin
				send_poll(ms_now, 1'b0, CNT_W'($urandom), 1'($urandom),
					RAW_W'($urandom), RAW_W'($urandom));
			end else begin
				ry = clip_raw(ry + int'($urandom_range(0, 120)) - 60);
				rx = clip_raw(rx + int'($urandom_range(0, 40)) - 20);
				send_poll(ms_now, 1'b1, CNT_W'($urandom_range(1, 15)), 1'b1,
					RAW_W'(rx), RAW_W'(ry));
			end
		end
		repeat ($urandom_range(1, 3)) begin
			ms_now += $urandom_range(0, tmo_cur + tmo_cur / 2 + 4);
			send_poll(ms_now, 1'($urandom_range(0, 1)), '0, 1'($urandom),
				RAW_W'($urandom), RAW_W'($urandom));
		end
	endtask

	task automatic run_phase(input int n);
		int first;
		first = polls_sent;
		while (polls_sent - first < n) begin
			if ($urandom_range(0, 4) == 0) begin
				ms_now += $urandom_range(0, 60);
				send_poll(($urandom_range(0, 4) == 0) ? TS_W'($urandom) : ms_now,
					1'($urandom), CNT_W'($urandom), 1'($urandom),
					RAW_W'($urandom), RAW_W'($urandom));
			end else begin
				run_touch();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		idle_on = 1'b1;
		polls_sent = 0;
		tmo_cur = 80;
		ms_now = '0;
		poll_ch.valid = 1'b0;
		poll_ch.now_ms = '0;
		poll_ch.count_read_ok = 1'b0;
		poll_ch.point_count = '0;
		poll_ch.coord_read_ok = 1'b0;
		poll_ch.raw_x = '0;
		poll_ch.raw_y = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DEVICE_ONLINE;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_poll(32'd1000, 1'b1, 4'd1, 1'b1, 12'd100, 12'd200);
		settle();
		set_online(1'b1);
		send_poll(32'd1000, 1'b1, 4'd1, 1'b1, 12'd4095, 12'd4095);
		send_poll(32'd1010, 1'b1, 4'd15, 1'b1, 12'd0, 12'd0);
		send_poll(32'd1020, 1'b1, 4'd1, 1'b1, 12'd0, 12'd0);
		send_poll(32'd1100, 1'b1, 4'd0, 1'b1, 12'd0, 12'd0);
		send_poll(32'd1101, 1'b1, 4'd0, 1'b1, 12'd0, 12'd0);
		send_poll(32'd1110, 1'b1, 4'd1, 1'b1, 12'd100, 12'd300);
		send_poll(32'd1120, 1'b1, 4'd1, 1'b0, 12'd4095, 12'd0);
		send_poll(32'd1130, 1'b1, 4'd1, 1'b1, 12'd100, 12'd360);
		send_poll(32'd1300, 1'b0, 4'd1, 1'b1, 12'd100, 12'd360);
		send_poll(32'd1310, 1'b1, 4'd1, 1'b1, 12'd100, 12'd100);
		send_poll(32'hFFFF_FFF0, 1'b1, 4'd0, 1'b0, 12'd0, 12'd0);
		send_poll(32'hFFFF_FFF8, 1'b1, 4'd2, 1'b1, 12'd50, 12'd50);
		send_poll(32'h0000_0010, 1'b1, 4'd0, 1'b1, 12'd0, 12'd0);
		send_poll(32'h0000_0020, 1'b1, 4'd1, 1'b1, 12'd50, 12'd95);
		send_poll(32'h0000_0030, 1'b1, 4'd1, 1'b1, 12'd50, 12'd96);
		send_poll(32'h0000_0200, 1'b1, 4'd0, 1'b1, 12'd0, 12'd0);
		send_poll(32'h0000_0210, 1'b1, 4'd1, 1'b1, 12'd100, 12'd100);
		send_poll(32'h0000_0220, 1'b1, 4'd1, 1'b1, 12'd200, 12'd0);
		send_poll(32'h0000_0230, 1'b1, 4'd1, 1'b1, 12'd201, 12'd0);
		send_poll(32'h0000_0240, 1'b1, 4'd1, 1'b1, 12'd199, 12'd0);
		ms_now = 32'h0000_0300;
		settle();

		set_timing(45, 80);
		run_phase(200);
		settle();
		set_timing(0, 0);
		run_phase(150);
		settle();
		set_timing(4095, 65535);
		run_phase(120);
		settle();
		set_online(1'b0);
		run_phase(40);
		settle();
		set_online(1'b1);
		set_timing($urandom_range(1, 120), $urandom_range(1, 400));
		run_phase(200);
		settle();
		idle_on = 1'b0;
		set_timing(30, 50);
		run_phase(180);
		settle();
		repeat (8) @(posedge clk);

		if (failures == 0)
			$display("[touch_swipe_tracker_core] OK");
		else
			$display("[touch_swipe_tracker_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
